### rtl/ebn_pkg.sv
// ebn_pkg: shared types, codes and helpers for the echo broadcast agreement node
// used by the top, ebn_cfg and ebn_core; no dependencies
`timescale 1ns / 1ps

package ebn_pkg;

  localparam int NODES_DEF = 4;

  localparam logic [7:0]  NO_VALUE    = 8'd255;
  localparam logic [15:0] TICKS_RESET = 16'd10;

  // input selector
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MSG   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // message kind
  localparam logic MSG_INIT = 1'b0;
  localparam logic MSG_ECHO = 1'b1;

  // result kind
  localparam logic [1:0] KIND_INIT    = 2'd0;
  localparam logic [1:0] KIND_ECHO    = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;
  localparam logic [1:0] KIND_FAULT   = 2'd3;

  // fault codes
  localparam logic [1:0] FC_DUP   = 2'd0;
  localparam logic [1:0] FC_PHASE = 2'd1;
  localparam logic [1:0] FC_ROUND = 2'd2;
  localparam logic [1:0] FC_BUSY  = 2'd3;
  // code field of a result that is not a fault
  localparam logic [1:0] FC_NONE  = 2'd0;

  // register index
  localparam logic REG_SKEW = 1'b0;
  localparam logic REG_SEND = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ACC_ECHO  = 3'd1,
    PH_ACC_INIT  = 3'd2,
    PH_WAIT_INIT = 3'd3,
    PH_WAIT_ECHO = 3'd4,
    PH_SETTLE    = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSG_RD,
    S_MSG_CHK,
    S_TICK,
    S_VOTE_RI,
    S_VOTE_LI,
    S_VOTE_CNT,
    S_VOTE_END,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [15:0] skew_ticks;
    logic [15:0] send_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] start_value;
    logic       msg_kind;
    logic [3:0] msg_sender;
    logic [7:0] msg_data;
    logic [7:0] msg_round;
  } item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_value;
    logic [3:0] out_sender;
    logic [7:0] out_round;
    logic [1:0] fault_code;
  } result_t;

  function automatic result_t make_res(logic [1:0] kind, logic [7:0] value,
                                       logic [3:0] sender, logic [7:0] rnd,
                                       logic [1:0] code);
    result_t r;
    r.out_kind   = kind;
    r.out_value  = value;
    r.out_sender = sender;
    r.out_round  = rnd;
    r.fault_code = code;
    return r;
  endfunction

  function automatic result_t fault_res(logic [1:0] code);
    return make_res(KIND_FAULT, 8'd0, 4'd0, 8'd0, code);
  endfunction

endpackage

### rtl/echo_broadcast_agreement_node_top.sv
// echo_broadcast_agreement_node_top: one node of an echo based reliable broadcast
// depends on ebn_pkg, ebn_cfg, ebn_core and ebn_ram
//
// in_* stream carries start, message and tick requests; out_* stream carries
// initial and echo broadcasts, the delivered majority and fault reports, at
// most one result per request. cfg_* is an apb port for skew_ticks (0x0) and
// send_ticks (0x4), pready always high.
// in_tready is high only while the sequencer is idle. a start, an ignored op
// or a tick while idle is taken in idle; a tick goes on through S_TICK, a
// message through S_MSG_RD and S_MSG_CHK, and a result through S_EMIT.
// the tick that ends the wait-for-echoes phase runs the vote over the echo
// table through one compare unit and one ram read port. a result is
// registered and appears on out_* in the cycle after the sequencer hands it over.
// reset (rst_n low, synchronous) puts the node idle with round 0, both slot
// tables empty and both registers at 10; no clearing pass is needed.
// a result held by a stalled receiver stays in the output register; the
// sequencer keeps working and waits only when it has a second result ready.
`timescale 1ns / 1ps

module echo_broadcast_agreement_node_top #(
  parameter int NODES = ebn_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // start_value, msg_sender, msg_data, msg_round, zero pad
  input  logic [2:0]  in_tuser,  // op, msg_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // out_value, out_sender, out_round, zero pad
  output logic [3:0]  out_tuser, // out_kind, fault_code
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ebn_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_valid, res_ready;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  ebn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign item.op          = in_tuser[1:0];
  assign item.msg_kind    = in_tuser[2];
  assign item.start_value = in_tdata[7:0];
  assign item.msg_sender  = in_tdata[11:8];
  assign item.msg_data    = in_tdata[19:12];
  assign item.msg_round   = in_tdata[27:20];

  ebn_core #(.NODES(NODES)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.out_round, out_r.out_sender, out_r.out_value};
  assign out_tuser  = {out_r.fault_code, out_r.out_kind};

`ifndef SYNTHESIS
  a_msg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] == OP_MSG) |=> !in_tready)
    else $error("message request did not hold off the input");

  a_fault_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == KIND_FAULT) |->
      (out_tdata[7:0] == 8'd0 && out_tdata[19:8] == 12'd0))
    else $error("fault result carries a payload");

  a_code_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != KIND_FAULT) |-> (out_tuser[3:2] == FC_NONE))
    else $error("non-fault result carries a fault code");
`endif

endmodule

### rtl/ebn_ram.sv
// ebn_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module ebn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ebn_cfg.sv
// ebn_cfg: apb register file holding skew_ticks and send_ticks
// depends on ebn_pkg
`timescale 1ns / 1ps

module ebn_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ebn_pkg::cfg_t cfg
);
  import ebn_pkg::*;

  logic [15:0] skew_r, skew_nxt;
  logic [15:0] send_r, send_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    skew_nxt = skew_r;
    send_nxt = send_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SKEW: skew_nxt = pwdata[15:0];
        REG_SEND: send_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skew_r <= TICKS_RESET;
      send_r <= TICKS_RESET;
    end else begin
      skew_r <= skew_nxt;
      send_r <= send_nxt;
    end
  end

  assign prdata         = {16'd0, (paddr[2] == REG_SEND) ? send_r : skew_r};
  assign cfg.skew_ticks = skew_r;
  assign cfg.send_ticks = send_r;

endmodule

### rtl/ebn_core.sv
// ebn_core: round sequencer with the shared compare unit and the two slot tables
// depends on ebn_pkg and ebn_ram
`timescale 1ns / 1ps

module ebn_core #(
  parameter int NODES = ebn_pkg::NODES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ebn_pkg::cfg_t    cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  ebn_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output ebn_pkg::result_t res
);
  import ebn_pkg::*;

  localparam int AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW  = $clog2(NODES + 1);
  localparam int SLOTS = 1 << AW;
  localparam logic [CW-1:0] LAST_J = CW'(NODES);
  localparam logic [AW-1:0] LAST_I = AW'(NODES - 1);
  localparam logic [CW-1:0] MAJ_C  = CW'(NODES / 2 + 1);
  localparam logic [4:0]    NODES_C = 5'(NODES);

  seq_state_t     st_r, st_nxt;
  phase_t         phase_r, phase_nxt;
  logic [7:0]     round_r, round_nxt;
  logic [7:0]     own_r, own_nxt;
  logic [16:0]    tick_r, tick_nxt;
  logic [7:0]     held_r, held_nxt;
  logic [SLOTS-1:0] ivalid_r, ivalid_nxt;
  logic [SLOTS-1:0] evalid_r, evalid_nxt;
  item_t          item_r, item_nxt;
  result_t        res_r, res_nxt;
  logic [AW-1:0]  rd_idx_r;
  logic [AW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     vi_r, vi_nxt;

  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           init_we, echo_we;
  logic [7:0]     init_rdata, echo_rdata;
  logic [7:0]     init_eff, echo_eff;
  logic           eq;
  logic [16:0]    tick_inc, plen;
  logic           sender_bad;
  logic           init_phase, echo_phase;

  assign waddr = item_r.msg_sender[AW-1:0];

  ebn_ram #(.WIDTH(8), .DEPTH(NODES)) u_init_ram (
    .clk   (clk),
    .we    (init_we),
    .waddr (waddr),
    .wdata (item_r.msg_data),
    .raddr (raddr),
    .rdata (init_rdata)
  );

  ebn_ram #(.WIDTH(8), .DEPTH(NODES)) u_echo_ram (
    .clk   (clk),
    .we    (echo_we),
    .waddr (waddr),
    .wdata (item_r.msg_data),
    .raddr (raddr),
    .rdata (echo_rdata)
  );

  assign init_eff   = ivalid_r[rd_idx_r] ? init_rdata : NO_VALUE;
  assign echo_eff   = evalid_r[rd_idx_r] ? echo_rdata : NO_VALUE;
  // shared compare unit for the vote
  assign eq         = (echo_eff == vi_r);
  assign tick_inc   = tick_r + 17'd1;
  assign plen       = (phase_r == PH_WAIT_INIT || phase_r == PH_WAIT_ECHO) ?
                      ({1'b0, cfg.skew_ticks} + {1'b0, cfg.send_ticks}) :
                      {1'b0, cfg.skew_ticks};
  assign sender_bad = ({1'b0, item_r.msg_sender} >= NODES_C);
  assign init_phase = (phase_r == PH_ACC_INIT || phase_r == PH_WAIT_INIT);
  assign echo_phase = (phase_r != PH_IDLE && phase_r != PH_SETTLE);

  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    round_nxt  = round_r;
    own_nxt    = own_r;
    tick_nxt   = tick_r;
    held_nxt   = held_r;
    ivalid_nxt = ivalid_r;
    evalid_nxt = evalid_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    vi_nxt     = vi_r;
    raddr      = item_r.msg_sender[AW-1:0];
    init_we    = 1'b0;
    echo_we    = 1'b0;
    item_ready = 1'b0;
    res_valid  = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt = item;
          unique case (item.op)
            OP_START: begin
              if (phase_r != PH_IDLE) begin
                res_nxt = fault_res(FC_BUSY);
                st_nxt  = S_EMIT;
              end else begin
                own_nxt   = item.start_value;
                phase_nxt = PH_ACC_ECHO;
                tick_nxt  = 17'd0;
              end
            end
            OP_MSG: st_nxt = S_MSG_RD;
            OP_TICK: begin
              if (phase_r != PH_IDLE) begin
                st_nxt = S_TICK;
              end
            end
            default: ;
          endcase
        end
      end

      S_MSG_RD: st_nxt = S_MSG_CHK;

      S_MSG_CHK: begin
        st_nxt = S_EMIT;
        if (item_r.msg_round != round_r) begin
          res_nxt = fault_res(FC_ROUND);
        end else if (item_r.msg_kind == MSG_INIT && init_phase) begin
          if (sender_bad) begin
            res_nxt = fault_res(FC_PHASE);
          end else if (init_eff != NO_VALUE) begin
            res_nxt = fault_res(FC_DUP);
          end else begin
            init_we           = 1'b1;
            ivalid_nxt[waddr] = 1'b1;
            res_nxt = make_res(KIND_ECHO, item_r.msg_data, item_r.msg_sender,
                               item_r.msg_round, FC_NONE);
          end
        end else if (echo_phase) begin
          if (sender_bad) begin
            res_nxt = fault_res(FC_PHASE);
          end else if (echo_eff != NO_VALUE) begin
            res_nxt = fault_res(FC_DUP);
          end else begin
            echo_we           = 1'b1;
            evalid_nxt[waddr] = 1'b1;
            st_nxt            = S_IDLE;
          end
        end else begin
          res_nxt = fault_res(FC_PHASE);
        end
      end

      S_TICK: begin
        st_nxt = S_IDLE;
        if (tick_inc < plen) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt = 17'd0;
          unique case (phase_r)
            PH_ACC_ECHO: phase_nxt = PH_ACC_INIT;
            PH_ACC_INIT: begin
              phase_nxt = PH_WAIT_INIT;
              if (own_r != NO_VALUE) begin
                res_nxt = make_res(KIND_INIT, own_r, 4'd0, round_r, FC_NONE);
                st_nxt  = S_EMIT;
              end
            end
            PH_WAIT_INIT: phase_nxt = PH_WAIT_ECHO;
            PH_WAIT_ECHO: begin
              held_nxt = NO_VALUE;
              i_nxt    = '0;
              st_nxt   = S_VOTE_RI;
            end
            PH_SETTLE: begin
              phase_nxt = PH_IDLE;
              res_nxt   = make_res(KIND_DELIVER, held_r, 4'd0, round_r, FC_NONE);
              st_nxt    = S_EMIT;
            end
            default: ;
          endcase
        end
      end

      S_VOTE_RI: begin
        raddr  = i_r;
        st_nxt = S_VOTE_LI;
      end

      S_VOTE_LI: begin
        vi_nxt  = echo_eff;
        raddr   = '0;
        j_nxt   = CW'(1);
        cnt_nxt = '0;
        st_nxt  = S_VOTE_CNT;
      end

      S_VOTE_CNT: begin
        cnt_nxt = cnt_r + CW'(eq);
        if (j_r == LAST_J) begin
          st_nxt = S_VOTE_END;
        end else begin
          raddr = j_r[AW-1:0];
          j_nxt = j_r + CW'(1);
        end
      end

      S_VOTE_END: begin
        if (cnt_r >= MAJ_C) begin
          held_nxt = vi_r;
        end
        if (i_r == LAST_I) begin
          ivalid_nxt = '0;
          evalid_nxt = '0;
          round_nxt  = round_r + 8'd1;
          phase_nxt  = PH_SETTLE;
          st_nxt     = S_IDLE;
        end else begin
          i_nxt  = i_r + AW'(1);
          st_nxt = S_VOTE_RI;
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      phase_r  <= PH_IDLE;
      round_r  <= 8'd0;
      own_r    <= NO_VALUE;
      tick_r   <= 17'd0;
      held_r   <= NO_VALUE;
      ivalid_r <= '0;
      evalid_r <= '0;
      i_r      <= '0;
      j_r      <= '0;
      cnt_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      round_r  <= round_nxt;
      own_r    <= own_nxt;
      tick_r   <= tick_nxt;
      held_r   <= held_nxt;
      ivalid_r <= ivalid_nxt;
      evalid_r <= evalid_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    vi_r     <= vi_nxt;
    rd_idx_r <= raddr;
  end

  assign res = res_r;

endmodule
